// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check under reset-qualified clocking
`define ISQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("isq assertion failed");

// check with no reset qualification
`define ISQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("isq assertion failed");

`else

`define ISQ_ASSERT(lbl, prop)
`define ISQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- hdl/isq_pkg.sv -----
package isq_pkg;

    localparam int PRICE_W = 32;
    localparam int ID_W    = 32;
    localparam int QTY_W   = 15;
    localparam int INV_W   = 16;
    localparam int CFG_W   = 16;
    localparam int RAW_W   = 35;
    localparam int SKEW_W  = 33;
    localparam int LIM_W   = 18;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int NSLOT   = 4;

    localparam logic [15:0] HALF_SPREAD_RST   = 16'd256;
    localparam logic [15:0] SKEW_PER_UNIT_RST = 16'd0;
    localparam logic [14:0] ORDER_QTY_RST     = 15'd1;
    localparam logic [14:0] INV_LIMIT_RST     = 15'd10;
    localparam logic [15:0] REQUOTE_THR_RST   = 16'd0;

    localparam logic OP_BOOK    = 1'b0;
    localparam logic OP_FILL    = 1'b1;
    localparam logic ACT_CANCEL = 1'b0;
    localparam logic ACT_PLACE  = 1'b1;
    localparam logic SIDE_BID   = 1'b0;
    localparam logic SIDE_ASK   = 1'b1;

    typedef enum logic [2:0] {
        REG_HALF_SPREAD   = 3'd0,
        REG_SKEW_PER_UNIT = 3'd1,
        REG_ORDER_QTY     = 3'd2,
        REG_INV_LIMIT     = 3'd3,
        REG_REQUOTE_THR   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [15:0] half_spread;
        logic [15:0] skew_per_unit;
        logic [14:0] order_quantity;
        logic [14:0] inventory_limit;
        logic [15:0] requote_threshold;
    } cfg_t;

    typedef struct packed {
        logic               is_fill;
        logic [ID_W-1:0]    fill_id;
        logic [PRICE_W-1:0] want_bid;
        logic [PRICE_W-1:0] want_ask;
        logic               can_buy;
        logic               can_sell;
    } qent_t;

    function automatic logic [PRICE_W-1:0] sat_price(input logic signed [RAW_W-1:0] v);
        logic [PRICE_W-1:0] r;
        if (v[RAW_W-1])
        begin
            r = '0;
        end
        else if (|v[RAW_W-2:PRICE_W])
        begin
            r = '1;
        end
        else
        begin
            r = v[PRICE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/isq_front.sv -----
module isq_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  isq_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic                  book_valid,
    input  logic [31:0]           best_bid,
    input  logic [31:0]           best_ask,
    input  logic signed [15:0]    inventory,
    input  logic [31:0]           fill_order_id,
    input  logic [14:0]           fill_remaining,
    input  logic                  q_full,
    output logic                  q_push,
    output isq_pkg::qent_t        q_wdata
);
    import isq_pkg::*;

    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_fill_reg;
    logic [ID_W-1:0]          s1_fid_reg;
    logic [PRICE_W-1:0]       s1_mid_reg;
    logic signed [SKEW_W-1:0] s1_skew_reg;
    logic signed [INV_W-1:0]  s1_inv_reg;

    logic                     accept;
    logic                     keep;
    logic [PRICE_W:0]         sum;
    logic signed [SKEW_W-1:0] skew;
    logic signed [RAW_W-1:0]  mid_w, hs_w, skew_w, raw_bid, raw_ask;
    logic signed [LIM_W-1:0]  inv_w, oq_w, lim_w;

    assign in_stall = s1_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign keep     = (op == OP_FILL) ? (fill_remaining == '0) : book_valid;
    assign sum      = {1'b0, best_bid} + {1'b0, best_ask};
    assign skew     = $signed({{(SKEW_W-INV_W){inventory[INV_W-1]}}, inventory})
                    * $signed({{(SKEW_W-CFG_W){1'b0}}, cfg.skew_per_unit});

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = keep;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fill_reg <= (op == OP_FILL);
            s1_fid_reg  <= fill_order_id;
            s1_mid_reg  <= sum[PRICE_W:1];
            s1_skew_reg <= skew;
            s1_inv_reg  <= inventory;
        end
    end

    // target prices and side limits
    always_comb
    begin
        mid_w   = $signed({{(RAW_W-PRICE_W){1'b0}}, s1_mid_reg});
        hs_w    = $signed({{(RAW_W-CFG_W){1'b0}}, cfg.half_spread});
        skew_w  = $signed({{(RAW_W-SKEW_W){s1_skew_reg[SKEW_W-1]}}, s1_skew_reg});
        raw_bid = mid_w - hs_w - skew_w;
        raw_ask = mid_w + hs_w - skew_w;
        inv_w   = $signed({{(LIM_W-INV_W){s1_inv_reg[INV_W-1]}}, s1_inv_reg});
        oq_w    = $signed({{(LIM_W-QTY_W){1'b0}}, cfg.order_quantity});
        lim_w   = $signed({{(LIM_W-QTY_W){1'b0}}, cfg.inventory_limit});

        q_wdata.is_fill  = s1_fill_reg;
        q_wdata.fill_id  = s1_fid_reg;
        q_wdata.want_bid = sat_price(raw_bid);
        q_wdata.want_ask = sat_price(raw_ask);
        q_wdata.can_buy  = (inv_w + oq_w) <= lim_w;
        q_wdata.can_sell = (inv_w - oq_w) >= (-lim_w);
    end

    assign q_push = s1_valid_reg && !q_full;

endmodule

// ----- hdl/isq_queue.sv -----
module isq_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  isq_pkg::qent_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output isq_pkg::qent_t rdata
);
    import isq_pkg::*;

    qent_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, wptr_next;
    logic [QAW-1:0] rptr_reg, rptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full  = (count_reg == QDEPTH[QAW:0]);
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/isq_back.sv -----
module isq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  isq_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  isq_pkg::qent_t q_rdata,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           action,
    output logic           side,
    output logic [31:0]    order_id,
    output logic [31:0]    price,
    output logic [14:0]    quantity,
    output logic           last
);
    import isq_pkg::*;

    // quote book state
    logic               bid_live_reg, bid_live_next;
    logic [ID_W-1:0]    bid_id_reg, bid_id_next;
    logic [PRICE_W-1:0] bid_quote_reg, bid_quote_next;
    logic               ask_live_reg, ask_live_next;
    logic [ID_W-1:0]    ask_id_reg, ask_id_next;
    logic [PRICE_W-1:0] ask_quote_reg, ask_quote_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;

    // pending words of the current item
    logic [NSLOT-1:0]   mask_reg, mask_next;
    logic [ID_W-1:0]    slot_id_reg [NSLOT];
    logic [PRICE_W-1:0] plc_bid_price_reg, plc_ask_price_reg;

    // output word
    logic               out_valid_reg, out_valid_next;
    logic               out_action_reg, out_side_reg, out_last_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [PRICE_W-1:0] out_price_reg;
    logic [QTY_W-1:0]   out_qty_reg;

    logic               issue;
    logic [1:0]         sel;
    logic [NSLOT-1:0]   mask_after;
    logic [PRICE_W-1:0] bid_mag, ask_mag;
    logic               cxl_bid, cxl_ask, plc_bid, plc_ask;
    logic               bid_kept, ask_kept;
    logic [ID_W-1:0]    bid_new_id, ask_new_id;
    logic               book_pop;

    always_comb
    begin
        sel = 2'd3;
        if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
    end

    assign issue      = (|mask_reg) && (!out_valid_reg || !out_stall);
    assign mask_after = mask_reg & ~(NSLOT'(1) << sel);
    assign q_pop      = q_valid && ((mask_reg == '0) || (issue && (mask_after == '0)));
    assign book_pop   = q_pop && !q_rdata.is_fill;

    // cancel and place decisions
    always_comb
    begin
        bid_mag    = (bid_quote_reg >= q_rdata.want_bid) ? bid_quote_reg - q_rdata.want_bid
                                                         : q_rdata.want_bid - bid_quote_reg;
        ask_mag    = (ask_quote_reg >= q_rdata.want_ask) ? ask_quote_reg - q_rdata.want_ask
                                                         : q_rdata.want_ask - ask_quote_reg;
        cxl_bid    = bid_live_reg && (!q_rdata.can_buy
                   || (bid_mag > {{(PRICE_W-CFG_W){1'b0}}, cfg.requote_threshold}));
        cxl_ask    = ask_live_reg && (!q_rdata.can_sell
                   || (ask_mag > {{(PRICE_W-CFG_W){1'b0}}, cfg.requote_threshold}));
        bid_kept   = bid_live_reg && !cxl_bid;
        ask_kept   = ask_live_reg && !cxl_ask;
        plc_bid    = q_rdata.can_buy && !bid_kept;
        plc_ask    = q_rdata.can_sell && !ask_kept;
        bid_new_id = next_id_reg;
        ask_new_id = next_id_reg + {{(ID_W-1){1'b0}}, plc_bid};
    end

    always_comb
    begin
        bid_live_next  = bid_live_reg;
        bid_id_next    = bid_id_reg;
        bid_quote_next = bid_quote_reg;
        ask_live_next  = ask_live_reg;
        ask_id_next    = ask_id_reg;
        ask_quote_next = ask_quote_reg;
        next_id_next   = next_id_reg;
        mask_next      = issue ? mask_after : mask_reg;
        if (q_pop && q_rdata.is_fill)
        begin
            if (bid_live_reg && (bid_id_reg == q_rdata.fill_id))
            begin
                bid_live_next = 1'b0;
            end
            if (ask_live_reg && (ask_id_reg == q_rdata.fill_id))
            begin
                ask_live_next = 1'b0;
            end
        end
        else if (book_pop)
        begin
            bid_live_next = bid_kept || plc_bid;
            ask_live_next = ask_kept || plc_ask;
            if (plc_bid)
            begin
                bid_id_next    = bid_new_id;
                bid_quote_next = q_rdata.want_bid;
            end
            if (plc_ask)
            begin
                ask_id_next    = ask_new_id;
                ask_quote_next = q_rdata.want_ask;
            end
            next_id_next = next_id_reg + {{(ID_W-1){1'b0}}, plc_bid}
                                       + {{(ID_W-1){1'b0}}, plc_ask};
            mask_next    = {plc_ask, plc_bid, cxl_ask, cxl_bid};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_live_reg  <= 1'b0;
            bid_id_reg    <= '0;
            bid_quote_reg <= '0;
            ask_live_reg  <= 1'b0;
            ask_id_reg    <= '0;
            ask_quote_reg <= '0;
            next_id_reg   <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bid_live_reg  <= bid_live_next;
            bid_id_reg    <= bid_id_next;
            bid_quote_reg <= bid_quote_next;
            ask_live_reg  <= ask_live_next;
            ask_id_reg    <= ask_id_next;
            ask_quote_reg <= ask_quote_next;
            next_id_reg   <= next_id_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (book_pop)
        begin
            slot_id_reg[0]    <= bid_id_reg;
            slot_id_reg[1]    <= ask_id_reg;
            slot_id_reg[2]    <= bid_new_id;
            slot_id_reg[3]    <= ask_new_id;
            plc_bid_price_reg <= q_rdata.want_bid;
            plc_ask_price_reg <= q_rdata.want_ask;
        end
        if (issue)
        begin
            out_action_reg <= sel[1] ? ACT_PLACE : ACT_CANCEL;
            out_side_reg   <= sel[0] ? SIDE_ASK : SIDE_BID;
            out_id_reg     <= slot_id_reg[sel];
            out_last_reg   <= (mask_after == '0);
            if (sel[1])
            begin
                out_price_reg <= sel[0] ? plc_ask_price_reg : plc_bid_price_reg;
                out_qty_reg   <= cfg.order_quantity;
            end
            else
            begin
                out_price_reg <= '0;
                out_qty_reg   <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = out_action_reg;
    assign side      = out_side_reg;
    assign order_id  = out_id_reg;
    assign price     = out_price_reg;
    assign quantity  = out_qty_reg;
    assign last      = out_last_reg;

endmodule

// ----- hdl/inventory_skew_quoter.sv -----
// Two-sided quoter skewed by inventory. Book words (op 0) with book_valid set
// reprice both sides from the floored mid, half_spread and inventory times
// skew_per_unit, cancel quotes that are out of limits or moved past
// requote_threshold, then place on empty allowed sides; fill words (op 1)
// with zero remaining clear the side whose id matches. Output words of one
// input come in the order bid cancel, ask cancel, bid place, ask place, with
// last on the final one. The input takes one word per cycle while the
// four-entry queue between the pricing front end and the quote-state back
// end has room. The back end takes a word from the queue in the same cycle
// it issues the final output word of the previous one, or in a cycle of its
// own when it has nothing pending, and then issues its output words (one to
// four) one per cycle while out_stall does not hold them; a book word with
// no action or a fill with zero remaining yields no output word. Empty-book
// words and fills with nonzero remaining are dropped at the input and never
// enter the queue. The path from input to the first output word runs through
// the front-end stage register, a queue entry and the output register.
`include "assert_macros.svh"

module inventory_skew_quoter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic                book_valid,
    input  logic [31:0]         best_bid,
    input  logic [31:0]         best_ask,
    input  logic signed [15:0]  inventory,
    input  logic [31:0]         fill_order_id,
    input  logic [14:0]         fill_remaining,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                action,
    output logic                side,
    output logic [31:0]         order_id,
    output logic [31:0]         price,
    output logic [14:0]         quantity,
    output logic                last
);
    import isq_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  q_push, q_full, q_pop, q_valid;
    qent_t q_wdata, q_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_SPREAD:   cfg_next.half_spread       = cfg_data;
                REG_SKEW_PER_UNIT: cfg_next.skew_per_unit     = cfg_data;
                REG_ORDER_QTY:     cfg_next.order_quantity    = cfg_data[QTY_W-1:0];
                REG_INV_LIMIT:     cfg_next.inventory_limit   = cfg_data[QTY_W-1:0];
                REG_REQUOTE_THR:   cfg_next.requote_threshold = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_spread       <= HALF_SPREAD_RST;
            cfg_reg.skew_per_unit     <= SKEW_PER_UNIT_RST;
            cfg_reg.order_quantity    <= ORDER_QTY_RST;
            cfg_reg.inventory_limit   <= INV_LIMIT_RST;
            cfg_reg.requote_threshold <= REQUOTE_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    isq_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .book_valid     (book_valid),
        .best_bid       (best_bid),
        .best_ask       (best_ask),
        .inventory      (inventory),
        .fill_order_id  (fill_order_id),
        .fill_remaining (fill_remaining),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_wdata        (q_wdata)
    );

    isq_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    isq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action),
        .side      (side),
        .order_id  (order_id),
        .price     (price),
        .quantity  (quantity),
        .last      (last)
    );

    `ISQ_ASSERT(a_no_push_when_full, q_push |-> !q_full)
    `ISQ_ASSERT(a_pop_needs_entry, q_pop |-> q_valid)
    `ISQ_ASSERT(a_words_contiguous, (out_valid && !out_stall && !last) |=> out_valid)

endmodule

// ----- tb/quote_book_checker.sv -----
`timescale 1ns / 1ps

module quote_book_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               op,
    input  logic               book_valid,
    input  logic [31:0]        best_bid,
    input  logic [31:0]        best_ask,
    input  logic signed [15:0] inventory,
    input  logic [31:0]        fill_order_id,
    input  logic [14:0]        fill_remaining,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               action,
    input  logic               side,
    input  logic [31:0]        order_id,
    input  logic [31:0]        price,
    input  logic [14:0]        quantity,
    input  logic               last,
    output int                 errors,
    output int                 pending,
    output int                 words_in,
    output int                 words_out
);
    import isq_pkg::*;

    localparam longint PRICE_TOP = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic        side;
        logic [31:0] order_id;
        logic [31:0] price;
        logic [14:0] quantity;
        logic        last;
    } quote_word_t;

    cfg_t        pricing;
    logic        bid_live;
    logic        ask_live;
    logic [31:0] bid_id;
    logic [31:0] ask_id;
    logic [31:0] bid_quote;
    logic [31:0] ask_quote;
    logic [31:0] next_id;
    quote_word_t due_words[$];

    function automatic logic [31:0] clamp_price(longint v);
        logic [31:0] r;
        if (v < 0)
            r = '0;
        else if (v > PRICE_TOP)
            r = '1;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic moved_off(logic live, logic [31:0] held, logic [31:0] target,
                                       logic allowed, logic [15:0] thr);
        longint drift;
        drift = longint'({32'd0, held}) - longint'({32'd0, target});
        if (drift < 0)
            drift = -drift;
        return live && (!allowed || drift > longint'({48'd0, thr}));
    endfunction

    function automatic quote_word_t form_action(logic act, logic sd, logic [31:0] id,
                                                logic [31:0] px, logic [14:0] qty);
        quote_word_t w;
        w.action   = act;
        w.side     = sd;
        w.order_id = id;
        w.price    = px;
        w.quantity = qty;
        w.last     = 1'b0;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        longint      pos;
        longint      mid;
        longint      skew;
        longint      spread;
        longint      qty;
        longint      lim;
        logic [31:0] want_bid;
        logic [31:0] want_ask;
        logic        can_buy;
        logic        can_sell;
        quote_word_t burst[4];
        quote_word_t got;
        quote_word_t want;
        int          n;
        if (!rst_n)
        begin
            pricing   = {HALF_SPREAD_RST, SKEW_PER_UNIT_RST, ORDER_QTY_RST,
                         INV_LIMIT_RST, REQUOTE_THR_RST};
            bid_live  = 1'b0;
            ask_live  = 1'b0;
            bid_id    = '0;
            ask_id    = '0;
            bid_quote = '0;
            ask_quote = '0;
            next_id   = '0;
            due_words.delete();
            errors    <= 0;
            pending   <= 0;
            words_in  <= 0;
            words_out <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HALF_SPREAD:   pricing.half_spread       = cfg_data;
                    REG_SKEW_PER_UNIT: pricing.skew_per_unit     = cfg_data;
                    REG_ORDER_QTY:     pricing.order_quantity    = cfg_data[14:0];
                    REG_INV_LIMIT:     pricing.inventory_limit   = cfg_data[14:0];
                    REG_REQUOTE_THR:   pricing.requote_threshold = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got = {action, side, order_id, price, quantity, last};
                words_out <= words_out + 1;
                if (due_words.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t: unexpected act=%0d side=%0d id=%h price=%h qty=%0d last=%0d",
                             $time, got.action, got.side, got.order_id, got.price,
                             got.quantity, got.last);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got !== want)
                    begin
                        errors <= errors + 1;
                        $display("%0t: expected act=%0d side=%0d id=%h price=%h qty=%0d last=%0d",
                                 $time, want.action, want.side, want.order_id, want.price,
                                 want.quantity, want.last);
                        $display("%0t: got      act=%0d side=%0d id=%h price=%h qty=%0d last=%0d",
                                 $time, got.action, got.side, got.order_id, got.price,
                                 got.quantity, got.last);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                words_in <= words_in + 1;
                if (op == OP_FILL)
                begin
                    if (fill_remaining == '0)
                    begin
                        if (bid_live && bid_id == fill_order_id)
                            bid_live = 1'b0;
                        if (ask_live && ask_id == fill_order_id)
                            ask_live = 1'b0;
                    end
                end
                else if (book_valid)
                begin
                    n        = 0;
                    pos      = longint'(inventory);
                    spread   = longint'({48'd0, pricing.half_spread});
                    qty      = longint'({49'd0, pricing.order_quantity});
                    lim      = longint'({49'd0, pricing.inventory_limit});
                    mid      = (longint'({32'd0, best_bid}) + longint'({32'd0, best_ask})) / 2;
                    skew     = pos * longint'({48'd0, pricing.skew_per_unit});
                    want_bid = clamp_price(mid - spread - skew);
                    want_ask = clamp_price(mid + spread - skew);
                    can_buy  = (pos + qty) <= lim;
                    can_sell = (pos - qty) >= -lim;

                    if (moved_off(bid_live, bid_quote, want_bid, can_buy,
                                  pricing.requote_threshold))
                    begin
                        burst[n] = form_action(ACT_CANCEL, SIDE_BID, bid_id, '0, '0);
                        n++;
                        bid_live = 1'b0;
                    end
                    if (moved_off(ask_live, ask_quote, want_ask, can_sell,
                                  pricing.requote_threshold))
                    begin
                        burst[n] = form_action(ACT_CANCEL, SIDE_ASK, ask_id, '0, '0);
                        n++;
                        ask_live = 1'b0;
                    end
                    if (can_buy && !bid_live)
                    begin
                        bid_id    = next_id;
                        next_id   = next_id + 32'd1;
                        bid_quote = want_bid;
                        bid_live  = 1'b1;
                        burst[n]  = form_action(ACT_PLACE, SIDE_BID, bid_id, want_bid,
                                                pricing.order_quantity);
                        n++;
                    end
                    if (can_sell && !ask_live)
                    begin
                        ask_id    = next_id;
                        next_id   = next_id + 32'd1;
                        ask_quote = want_ask;
                        ask_live  = 1'b1;
                        burst[n]  = form_action(ACT_PLACE, SIDE_ASK, ask_id, want_ask,
                                                pricing.order_quantity);
                        n++;
                    end
                    for (int k = 0; k < n; k++)
                    begin
                        burst[k].last = (k == n - 1);
                        due_words.push_back(burst[k]);
                    end
                end
            end

            pending <= due_words.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import isq_pkg::*;

    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 24;
    localparam int         LIMIT_CYCLES    = 400000;
    localparam logic [2:0] REG_SPARE       = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic               book_valid;
    logic [31:0]        best_bid;
    logic [31:0]        best_ask;
    logic signed [15:0] inventory;
    logic [31:0]        fill_order_id;
    logic [14:0]        fill_remaining;
    logic               out_valid;
    logic               out_stall;
    logic               action;
    logic               side;
    logic [31:0]        order_id;
    logic [31:0]        price;
    logic [14:0]        quantity;
    logic               last;

    int                 errors;
    int                 pending;
    int                 words_in;
    int                 words_out;

    bit                 squeeze_req;
    bit                 eager;
    int                 settings_done;
    logic [15:0]        cur_thr;
    logic [14:0]        cur_lim;
    logic [31:0]        book_bid;
    logic [31:0]        book_ask;
    logic [15:0]        book_pos;
    logic [31:0]        placed_ids[$];

    inventory_skew_quoter u_dut (.*);

    quote_book_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // remember recent order ids so fills can name live quotes
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall && action == ACT_PLACE)
        begin
            placed_ids.push_back(order_id);
            if (placed_ids.size() > 8)
                void'(placed_ids.pop_front());
        end
    end

    initial
    begin : receiver
        int left;
        bit squeeze_done;
        left         = 0;
        squeeze_done = 1'b0;
        out_stall    = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                left = 0;
            end
            else if (left > 0)
            begin
                left--;
            end
            else if (out_stall)
            begin
                out_stall <= 1'b0;
                left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 5);
            end
            else
            begin
                left = idle_span();
                if (left > 0)
                begin
                    out_stall <= 1'b1;
                    left--;
                end
            end
        end
    end

    task automatic send_word(logic o, logic bv, logic [31:0] bb, logic [31:0] ba,
                             logic [15:0] pos, logic [31:0] fid, logic [14:0] rest);
        int span;
        span = eager ? 0 : idle_span();
        if (span > 0)
        begin
            in_valid <= 1'b0;
            repeat (span) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        book_valid     <= bv;
        best_bid       <= bb;
        best_ask       <= ba;
        inventory      <= pos;
        fill_order_id  <= fid;
        fill_remaining <= rest;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_book(logic [31:0] bb, logic [31:0] ba, logic [15:0] pos);
        send_word(OP_BOOK, 1'b1, bb, ba, pos, $urandom, 15'($urandom));
    endtask

    task automatic send_fill(logic [31:0] fid, logic [14:0] rest);
        send_word(OP_FILL, 1'($urandom), $urandom, $urandom, 16'($urandom), fid, rest);
    endtask

    // drop valid, let every expected word arrive, then let silent words drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pricing(logic [15:0] spread, logic [15:0] tilt, logic [14:0] qty,
                               logic [14:0] lim, logic [15:0] thr);
        wait_idle();
        write_reg(REG_HALF_SPREAD, spread);
        write_reg(REG_SKEW_PER_UNIT, tilt);
        write_reg(REG_ORDER_QTY, {1'b0, qty});
        write_reg(REG_INV_LIMIT, {1'b0, lim});
        write_reg(REG_REQUOTE_THR, thr);
        write_reg(REG_SPARE, 16'($urandom));
        cur_lim = lim;
        cur_thr = thr;
        settings_done++;
    endtask

    task automatic random_burst(int count);
        int          done;
        int          roll;
        int          reach;
        logic [31:0] span;
        logic [31:0] fid;
        logic [14:0] rest;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                send_word(OP_BOOK, 1'b0, $urandom, $urandom, 16'($urandom), $urandom,
                          15'($urandom));
            end
            else if (roll < 30)
            begin
                if (placed_ids.size() > 0 && $urandom_range(0, 3) != 0)
                    fid = placed_ids[$urandom_range(0, placed_ids.size() - 1)];
                else
                    fid = $urandom;
                rest = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'd0;
                send_fill(fid, rest);
                if (rest == '0)
                    done++;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                begin
                    book_bid = $urandom;
                    book_ask = $urandom;
                end
                else if (roll < 10)
                begin
                    book_bid = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                    book_ask = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                end
                else if (roll < 55)
                begin
                    span = $urandom_range(0, 2 * cur_thr + 2);
                    if ($urandom_range(0, 1))
                    begin
                        book_bid = book_bid + span;
                        book_ask = book_ask + span;
                    end
                    else
                    begin
                        book_bid = book_bid - span;
                        book_ask = book_ask - span;
                    end
                end
                else if (roll < 75)
                begin
                    // widen around the same mid
                    span = $urandom_range(0, 1024);
                    book_bid = book_bid - span;
                    book_ask = book_ask + span;
                end

                roll = $urandom_range(0, 99);
                if (roll < 30)
                begin
                    reach = (cur_lim + 2 > 32767) ? 32767 : cur_lim + 2;
                    book_pos = 16'($urandom_range(0, 2 * reach) - reach);
                end
                else if (roll < 40)
                begin
                    book_pos = 16'($urandom);
                end
                send_book(book_bid, book_ask, book_pos);
                done++;
            end
        end
    endtask

    initial
    begin : stimulus
        int oq;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        op             = OP_BOOK;
        book_valid     = 1'b0;
        best_bid       = '0;
        best_ask       = '0;
        inventory      = '0;
        fill_order_id  = '0;
        fill_remaining = '0;
        squeeze_req    = 1'b0;
        eager          = 1'b0;
        settings_done  = 0;
        cur_lim        = INV_LIMIT_RST;
        cur_thr        = REQUOTE_THR_RST;
        book_bid       = 32'h0001_0000;
        book_ask       = 32'h0001_0400;
        book_pos       = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // pricing from reset
        send_word(OP_BOOK, 1'b0, '1, '1, '1, '1, '1);
        send_book(32'h0001_0000, 32'h0001_0400, 16'sd0);
        send_book(32'h0001_0000, 32'h0001_0400, 16'sd0);
        send_fill(32'd0, 15'd5);
        send_fill(32'd0, 15'd0);
        send_book(32'h0001_0000, 32'h0001_0400, 16'sd0);
        send_book(32'h0001_0000, 32'h0001_0402, 16'sd0);
        send_book(32'h0001_0000, 32'h0001_0402, 16'sd10);
        send_book(32'h0001_0000, 32'h0001_0402, -16'sd10);
        send_book(32'h0001_0000, 32'h0001_0402, 16'sh7FFF);
        send_book(32'h0001_0000, 32'h0001_0402, 16'sh8000);
        send_book(32'd0, 32'd0, 16'sd0);
        send_book(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sd0);
        send_fill(32'hFFFF_FFFF, 15'd0);
        send_fill(32'd3, 15'h7FFF);
        send_book(32'h0000_2000, 32'h0000_1000, 16'sd0);

        // zero spread and quantity, tight limit, steep skew
        set_pricing(16'd0, 16'hFFFF, 15'd0, 15'd0, 16'd0);
        send_book(32'h8000_0000, 32'h8000_0000, 16'sd0);
        send_book(32'h8000_0000, 32'h8000_0000, 16'sd1);
        send_book(32'h8000_0000, 32'h8000_0000, -16'sd1);
        send_book(32'h0000_0100, 32'h0000_0100, 16'sh7FFF);
        send_book(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'sh8000);

        // widest spread, largest quantity and limit, loosest requote
        set_pricing(16'hFFFF, 16'd0, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        send_book(32'h0010_0000, 32'h0010_0000, 16'sd0);
        send_book(32'h0010_0000, 32'h0010_FFFE, 16'sd0);
        send_book(32'h0012_0000, 32'h0012_0000, 16'sd1);
        send_book(32'd0, 32'd0, -16'sd1);

        for (int k = 0; k < 4; k++)
        begin
            oq = $urandom_range(1, 4);
            if (k == 3)
                set_pricing(16'($urandom), 16'($urandom), 15'($urandom), 15'($urandom),
                            16'($urandom));
            else
                set_pricing(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 48)),
                            15'(oq), 15'(oq + $urandom_range(0, 16)),
                            16'($urandom_range(0, 64)));
            book_pos = '0;
            if (k == 1)
            begin
                // hold the output and keep offering so the block backs up
                squeeze_req = 1'b1;
                eager       = 1'b1;
                for (int j = 0; j < 24; j++)
                begin
                    book_bid = book_bid + 32'h0004_0000;
                    book_ask = book_ask + 32'h0004_0000;
                    send_book(book_bid, book_ask, book_pos);
                end
                eager = 1'b0;
            end
            random_burst(12);
        end

        wait_idle();
        $display("covered %0d input words and %0d quote actions under %0d pricing settings,",
                 words_in, words_out, settings_done + 1);
        $display("with one %0d-cycle output hold-off while input kept coming", HOLD_OFF_CYCLES);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

endmodule
